// ===== hw/rtl/sbmm_pkg.sv =====
// Shared types and constants for the system bus memory map.
// Used by sbmm_console and system_bus_memory_map; no dependencies.
package sbmm_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_FINISH
  } state_e;

  typedef enum logic [1:0] {
    REQ_FETCH   = 2'd0,
    REQ_STORE   = 2'd1,
    REQ_PRELOAD = 2'd2,
    REQ_NOP     = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    SEG_ROM,
    SEG_RAM,
    SEG_CON,
    SEG_NONE
  } seg_e;

  localparam logic [63:0] CON_BASE  = 64'hFFFF_FFFF_FFFF_F000;
  localparam logic [7:0]  FILL_BYTE = 8'hCC;
  localparam logic [63:0] FILL_WORD = {8{FILL_BYTE}};
  localparam logic [7:0]  ROM_FILL  = 8'hAA;
  localparam logic [19:0] QUIT_MASK = 20'hFFFFF;

  // console window byte offsets
  localparam logic [2:0] CON_OFF_TX   = 3'd0;
  localparam logic [2:0] CON_OFF_STAT = 3'd1;
  localparam logic [2:0] CON_OFF_RXD  = 3'd2;

  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [2:0]  off;
    logic [1:0]  size;
    logic [63:0] wdata;
    logic        rx_ready;
    logic [7:0]  rx_char;
  } con_req_t;

  typedef struct packed {
    logic [63:0] rdata;
    logic        rx_taken;
    logic        tx_valid;
    logic [7:0]  tx_char;
    logic        quit;
  } con_rsp_t;

  function automatic logic [3:0] byte_count(input logic [1:0] size);
    byte_count = 4'd1 << size;
  endfunction

  function automatic logic [63:0] size_mask(input logic [1:0] size);
    logic [63:0] m;
    unique case (size)
      2'd0: m = 64'h0000_0000_0000_00FF;
      2'd1: m = 64'h0000_0000_0000_FFFF;
      2'd2: m = 64'h0000_0000_FFFF_FFFF;
      2'd3: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/sbmm_console.sv =====
// Console window registers: baud word, quit flag, byte-lane read and write.
// Depends on sbmm_pkg.
module sbmm_console (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbmm_pkg::con_req_t req_i,
  output sbmm_pkg::con_rsp_t rsp_o
);
  import sbmm_pkg::*;

  logic [31:0] baud_q, baud_d;
  logic        quit_q, quit_d;
  logic        baud_hit;
  logic [3:0]  n, lo, hi, pos;
  logic [2:0]  o, bidx;
  logic [7:0]  lane_byte;
  logic [63:0] rd;
  logic        taken;

  always_comb begin
    n         = byte_count(req_i.size);
    lo        = {1'b0, req_i.off};
    hi        = lo + n;
    rd        = '0;
    taken     = 1'b0;
    o         = '0;
    lane_byte = '0;
    for (int j = 0; j < 8; j++) begin
      if (4'(j) < n) begin
        o = req_i.off + 3'(j);
        priority if (o[2]) begin
          lane_byte = baud_q[8*o[1:0] +: 8];
        end else if (o == CON_OFF_STAT) begin
          lane_byte = {7'd0, req_i.rx_ready};
        end else if (o == CON_OFF_RXD) begin
          lane_byte = req_i.rx_char;
          taken     = 1'b1;
        end else begin
          lane_byte = FILL_BYTE;
        end
        rd[8*j +: 8] = lane_byte;
      end
    end

    baud_d   = baud_q;
    baud_hit = 1'b0;
    pos      = '0;
    bidx     = '0;
    for (int m = 0; m < 4; m++) begin
      pos = 4'(4 + m);
      if (req_i.wr && pos >= lo && pos < hi) begin
        bidx               = 3'(pos - lo);
        baud_d[8*m +: 8]   = req_i.wdata[8*bidx +: 8];
        baud_hit           = 1'b1;
      end
    end
    quit_d = baud_hit ? (baud_d[19:0] == QUIT_MASK) : quit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baud_q <= '0;
      quit_q <= 1'b0;
    end else begin
      baud_q <= baud_d;
      quit_q <= quit_d;
    end
  end

  assign rsp_o.rdata    = req_i.rd ? rd : '0;
  assign rsp_o.rx_taken = req_i.rd && taken;
  assign rsp_o.tx_valid = req_i.wr && (req_i.off == CON_OFF_TX);
  assign rsp_o.tx_char  = (req_i.wr && (req_i.off == CON_OFF_TX)) ? req_i.wdata[7:0] : 8'd0;
  assign rsp_o.quit     = quit_q;

endmodule

// ===== hw/rtl/system_bus_memory_map.sv =====
// System bus memory map: ROM, RAM and console window behind one transaction port.
// ROM/RAM accesses go one byte per cycle through the byte-wide memories, for a transaction of
// n bytes (n = 1,2,4,8); console, error, misaligned fetch, ROM store and no-op transactions
// skip the memories and go straight to the result.
// Result is registered; the next transaction is accepted while it waits to be taken.
// Reset is asynchronous; afterwards ROM is filled with 0xAA, one byte a cycle, with
// in_ready_o low. Depends on sbmm_pkg and sbmm_console.
module system_bus_memory_map #(
  parameter int ROM_BYTES = 65536,
  parameter int RAM_BYTES = 65536,
  parameter int RAM_BASE  = 1073741824
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] addr_i,
  input  logic [1:0]  size_code_i,
  input  logic [63:0] wdata_i,
  input  logic        rx_ready_i,
  input  logic [7:0]  rx_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] rdata_o,
  output logic        misaligned_o,
  output logic        access_error_o,
  output logic        rx_taken_o,
  output logic        tx_valid_o,
  output logic [7:0]  tx_char_o,
  output logic        quit_request_o
);
  import sbmm_pkg::*;

  localparam int ROM_AW = $clog2(ROM_BYTES);
  localparam int RAM_AW = $clog2(RAM_BYTES);
  localparam logic [ROM_AW-1:0] ROM_LAST = ROM_AW'(ROM_BYTES - 1);
  localparam logic [RAM_AW-1:0] RAM_LAST = RAM_AW'(RAM_BYTES - 1);

  // ---------------------------------------------------------------------------
  // Address decode of the incoming transaction (first byte decides the segment)
  // ---------------------------------------------------------------------------
  logic [63:0] ram_off;
  seg_e        seg_in;
  logic        mis_in;

  always_comb begin
    ram_off = addr_i - 64'(RAM_BASE);
    priority if (addr_i < 64'(ROM_BYTES)) begin
      seg_in = SEG_ROM;
    end else if (addr_i >= 64'(RAM_BASE) && ram_off < 64'(RAM_BYTES)) begin
      seg_in = SEG_RAM;
    end else if (addr_i[63:3] == CON_BASE[63:3]) begin
      seg_in = SEG_CON;
    end else begin
      seg_in = SEG_NONE;
    end
    unique case (size_code_i)
      2'd0: mis_in = 1'b0;
      2'd1: mis_in = addr_i[0];
      2'd2: mis_in = |addr_i[1:0];
      2'd3: mis_in = |addr_i[2:0];
    endcase
  end

  // ---------------------------------------------------------------------------
  // Transaction registers, captured at accept
  // ---------------------------------------------------------------------------
  req_e        type_q;
  seg_e        seg_q;
  logic        mis_q;
  logic [1:0]  size_q;
  logic [2:0]  con_off_q;
  logic [63:0] wdata_q;
  logic        rxr_q;
  logic [7:0]  rxc_q;

  // sequencer state
  state_e            state_q, state_d;
  logic [2:0]        cnt_q, cnt_d;
  logic [ROM_AW-1:0] rom_idx_q, rom_idx_d;
  logic [RAM_AW-1:0] ram_idx_q, ram_idx_d;
  logic [ROM_AW-1:0] clr_idx_q, clr_idx_d;
  logic              rd_pend_q, rd_pend_d;
  logic [2:0]        rd_lane_q, rd_lane_d;

  // result being built
  logic [63:0] rdata_q, rdata_d;
  logic        mis_res_q, mis_res_d;
  logic        err_q, err_d;
  logic        taken_q, taken_d;
  logic        tx_q, tx_d;
  logic [7:0]  txc_q, txc_d;

  // output register
  logic        out_valid_q;
  logic        out_load;

  // memory ports
  logic              rom_we, rom_re, ram_we, ram_re;
  logic [ROM_AW-1:0] rom_waddr;
  logic [7:0]        rom_wbyte, mem_wbyte;
  logic [7:0]        rom_rdata_q, ram_rdata_q;

  con_req_t con_req;
  con_rsp_t con_rsp;

  // operation classes of the held transaction
  logic       is_fetch, is_store, fetch_mem, ram_wr_op, rom_wr_op, mem_op;
  logic [2:0] last_cnt;

  always_comb begin
    is_fetch  = (type_q == REQ_FETCH);
    is_store  = (type_q == REQ_STORE);
    fetch_mem = is_fetch && !mis_q && (seg_q == SEG_ROM || seg_q == SEG_RAM);
    ram_wr_op = is_store && (seg_q == SEG_RAM);   // misaligned RAM stores still write
    rom_wr_op = (type_q == REQ_PRELOAD) && (seg_q == SEG_ROM);
    mem_op    = fetch_mem || ram_wr_op || rom_wr_op;
    last_cnt  = 3'(byte_count(size_q) - 4'd1);
    mem_wbyte = wdata_q[8*cnt_q +: 8];
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state, memory strobes, result assembly
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cnt_d      = cnt_q;
    rom_idx_d  = rom_idx_q;
    ram_idx_d  = ram_idx_q;
    clr_idx_d  = clr_idx_q;
    rom_we     = 1'b0;
    rom_re     = 1'b0;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    rom_waddr  = rom_idx_q;
    rom_wbyte  = mem_wbyte;
    rd_pend_d  = 1'b0;
    rd_lane_d  = cnt_q;
    rdata_d    = rdata_q;
    mis_res_d  = mis_res_q;
    err_d      = err_q;
    taken_d    = taken_q;
    tx_d       = tx_q;
    txc_d      = txc_q;
    out_load   = 1'b0;

    con_req          = '0;
    con_req.off      = con_off_q;
    con_req.size     = size_q;
    con_req.wdata    = wdata_q;
    con_req.rx_ready = rxr_q;
    con_req.rx_char  = rxc_q;

    // read data lands in the cycle after its address; drop it into its byte lane
    if (rd_pend_q) begin
      rdata_d[8*rd_lane_q +: 8] = (seg_q == SEG_ROM) ? rom_rdata_q : ram_rdata_q;
    end

    unique case (state_q)
      ST_CLEAR: begin
        rom_we    = 1'b1;
        rom_waddr = clr_idx_q;
        rom_wbyte = ROM_FILL;
        clr_idx_d = clr_idx_q + 1'b1;
        if (clr_idx_q == ROM_LAST) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d   = ST_RUN;
          cnt_d     = '0;
          rom_idx_d = addr_i[ROM_AW-1:0];
          ram_idx_d = ram_off[RAM_AW-1:0];
          rdata_d   = '0;
          mis_res_d = 1'b0;
          err_d     = 1'b0;
          taken_d   = 1'b0;
          tx_d      = 1'b0;
          txc_d     = '0;
        end
      end

      ST_RUN: begin
        if (mem_op) begin
          // one byte per cycle, index wraps at the segment end
          rom_re    = fetch_mem && (seg_q == SEG_ROM);
          ram_re    = fetch_mem && (seg_q == SEG_RAM);
          rom_we    = rom_wr_op;
          ram_we    = ram_wr_op;
          rd_pend_d = fetch_mem;
          cnt_d     = cnt_q + 3'd1;
          rom_idx_d = (rom_idx_q == ROM_LAST) ? '0 : rom_idx_q + 1'b1;
          ram_idx_d = (ram_idx_q == RAM_LAST) ? '0 : ram_idx_q + 1'b1;
          if (cnt_q == last_cnt) begin
            state_d = ST_FINISH;
          end
        end else begin
          state_d = ST_FINISH;
        end

        if (cnt_q == 3'd0) begin
          err_d     = ((is_fetch || is_store) && seg_q == SEG_NONE) ||
                      (type_q == REQ_PRELOAD && seg_q != SEG_ROM);
          mis_res_d = (is_fetch || is_store) && seg_q != SEG_NONE && mis_q;
          if (is_fetch && (seg_q == SEG_NONE || mis_q)) begin
            rdata_d = FILL_WORD & size_mask(size_q);
          end
          // console is touched only by aligned transactions
          con_req.rd = is_fetch && seg_q == SEG_CON && !mis_q;
          con_req.wr = is_store && seg_q == SEG_CON && !mis_q;
          if (con_req.rd) begin
            rdata_d = con_rsp.rdata;
            taken_d = con_rsp.rx_taken;
          end
          if (con_req.wr) begin
            tx_d  = con_rsp.tx_valid;
            txc_d = con_rsp.tx_char;
          end
        end
      end

      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      clr_idx_q   <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      clr_idx_q <= clr_idx_d;
      rd_pend_q <= rd_pend_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      type_q    <= req_e'(req_type_i);
      seg_q     <= seg_in;
      mis_q     <= mis_in;
      size_q    <= size_code_i;
      con_off_q <= addr_i[2:0];
      wdata_q   <= wdata_i;
      rxr_q     <= rx_ready_i;
      rxc_q     <= rx_char_i;
    end
    rom_idx_q <= rom_idx_d;
    ram_idx_q <= ram_idx_d;
    rd_lane_q <= rd_lane_d;
    rdata_q   <= rdata_d;
    mis_res_q <= mis_res_d;
    err_q     <= err_d;
    taken_q   <= taken_d;
    tx_q      <= tx_d;
    txc_q     <= txc_d;
    if (out_load) begin
      rdata_o        <= rdata_d;
      misaligned_o   <= mis_res_q;
      access_error_o <= err_q;
      rx_taken_o     <= taken_q;
      tx_valid_o     <= tx_q;
      tx_char_o      <= txc_q;
      quit_request_o <= con_rsp.quit;
    end
  end

  assign out_valid_o = out_valid_q;

  // ---------------------------------------------------------------------------
  // Byte-wide memories, registered read
  // ---------------------------------------------------------------------------
  logic [7:0] rom_mem [ROM_BYTES];
  logic [7:0] ram_mem [RAM_BYTES];

  always_ff @(posedge clk_i) begin
    if (rom_we) begin
      rom_mem[rom_waddr] <= rom_wbyte;
    end
    if (rom_re) begin
      rom_rdata_q <= rom_mem[rom_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      ram_mem[ram_idx_q] <= mem_wbyte;
    end
    if (ram_re) begin
      ram_rdata_q <= ram_mem[ram_idx_q];
    end
  end

  // ---------------------------------------------------------------------------
  // Console window
  // ---------------------------------------------------------------------------
  sbmm_console u_console (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (con_req),
    .rsp_o  (con_rsp)
  );

endmodule

// ===== hw/rtl/sbmm_checker.sv =====
// Port-level checks for system_bus_memory_map, attached by bind.
// Depends only on the top level's ports.
module sbmm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [1:0]  req_type_i,
  input logic [63:0] addr_i,
  input logic [1:0]  size_code_i,
  input logic [63:0] wdata_i,
  input logic        rx_ready_i,
  input logic [7:0]  rx_char_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] rdata_o,
  input logic        misaligned_o,
  input logic        access_error_o,
  input logic        rx_taken_o,
  input logic        tx_valid_o,
  input logic [7:0]  tx_char_o,
  input logic        quit_request_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rdata_o) && $stable(tx_char_o))
    else $error("result changed while stalled");

  // one transaction at a time: busy right after accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("accepted back to back");

  a_err_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(misaligned_o && access_error_o))
    else $error("misaligned and access error together");

  a_tx_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> tx_char_o == 8'd0)
    else $error("tx_char set without tx_valid");

  a_taken_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rx_taken_o |-> !misaligned_o && !access_error_o && !tx_valid_o)
    else $error("rx_taken on a faulted or store transaction");

endmodule

bind system_bus_memory_map sbmm_checker u_sbmm_checker (.*);
